>>> hw/rtl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared constants, codes and types of the run blob bounding box block.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH        = 256;
  localparam int MAX_HEIGHT       = 256;
  localparam int MAX_RUNS_PER_ROW = 128;
  localparam int MARGIN           = 5;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int RIDX_W     = (MAX_RUNS_PER_ROW > 1) ? $clog2(MAX_RUNS_PER_ROW) : 1;
  localparam int CNT_W      = $clog2(MAX_RUNS_PER_ROW + 1);
  localparam int DIM_W      = 9;
  localparam int RUN_W      = 2 * COL_W + 1;
  localparam int RUN_DEPTH  = MAX_HEIGHT * MAX_RUNS_PER_ROW;
  localparam int FR_DEPTH   = 2 * MAX_RUNS_PER_ROW;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_WIDTH    = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0] minx;
    logic [COL_W-1:0] maxx;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
  } box_ext_t;

endpackage

>>> hw/rtl/rbb_if.sv
// ----------------------------------------------------------------------------
// rbb_if
// Channels of the run blob bounding box block: input, result, config write.
// ----------------------------------------------------------------------------
interface rbb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pixel;
  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface rbb_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic signed [8:0] box_x;
  logic signed [8:0] box_y;
  logic [8:0]        box_width;
  logic [8:0]        box_height;
  modport source (output valid, output found, output box_x, output box_y,
                  output box_width, output box_height, input ready);
  modport sink   (input valid, input found, input box_x, input box_y,
                  input box_width, input box_height, output ready);
endinterface

interface rbb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rbb_ram.sv
// ----------------------------------------------------------------------------
// rbb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rbb_box.sv
// ----------------------------------------------------------------------------
// rbb_box
// Turns an object's extent into a margin-widened, saturated box.
// ----------------------------------------------------------------------------
module rbb_box (
  input  logic              found_i,
  input  logic [7:0]        origin_x_i,
  input  logic [7:0]        origin_y_i,
  input  rbb_pkg::box_ext_t ext_i,
  output logic signed [8:0] box_x_o,
  output logic signed [8:0] box_y_o,
  output logic [8:0]        box_width_o,
  output logic [8:0]        box_height_o
);

  logic signed [10:0] sx, sy;
  logic [9:0]         w, h;

  always_comb begin
    sx = $signed(11'({3'b0, origin_x_i}) + 11'(ext_i.minx) - 11'(rbb_pkg::MARGIN));
    sy = $signed(11'({3'b0, origin_y_i}) + 11'(ext_i.top) - 11'(rbb_pkg::MARGIN));
    w  = 10'(ext_i.maxx) - 10'(ext_i.minx) + 10'(2 * rbb_pkg::MARGIN);
    h  = 10'(ext_i.bottom) - 10'(ext_i.top) + 10'(2 * rbb_pkg::MARGIN);
    if (!found_i) begin
      box_x_o      = '0;
      box_y_o      = '0;
      box_width_o  = '0;
      box_height_o = '0;
    end else begin
      box_x_o      = (sx > 11'sd255) ? 9'sd255 : sx[8:0];
      box_y_o      = (sy > 11'sd255) ? 9'sd255 : sy[8:0];
      box_width_o  = (w > 10'd511) ? 9'd511 : w[8:0];
      box_height_o = (h > 10'd511) ? 9'd511 : h[8:0];
    end
  end

endmodule

>>> hw/rtl/run_blob_bounding_boxes_core.sv
// ----------------------------------------------------------------------------
// run_blob_bounding_boxes_core
// Run-length blob extraction with downward growth and bounding boxes.
// ----------------------------------------------------------------------------
// Usage: words on in_i carry an op and a pixel. Pixel words (op 0) arrive in
// raster order and are taken while no fetch runs; runs of pixels other than 1
// are stored per row. A clear word (op 2) restarts the frame.
// A fetch word (op 1) returns one word on out_o: a box, or found = 0 once no
// runs remain. Config writes on cfg_i (origin, region size) are always
// accepted and are meant for idle periods.
// Fetch: a sequencer walks the stored runs through one shared compare unit,
// searching the rows for a run not yet taken, then growing the blob row by
// row: each run of the next row is read and compared with the frontier runs,
// and the result is then handed to the output register. in_i.ready is low
// during a fetch.
// Throughput: one pixel or clear per cycle while no fetch is running.
// A result waits in the output register while out_o is stalled; further
// pixel words are still taken, a new fetch holds at its end until the
// register frees. Reset empties the store and resets the frame position and config.
// ----------------------------------------------------------------------------
module run_blob_bounding_boxes_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbb_in_if.sink   in_i,
  rbb_out_if.source out_o,
  rbb_cfg_if.sink  cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROW_RD, S_ROW_CNT, S_SCAN_RD, S_SCAN_CHK, S_GROW,
    S_GCNT_RD, S_GCNT, S_GRUN_RD, S_GRUN, S_FR_RD, S_FR, S_DONE
  } state_e;

  localparam int CW = rbb_pkg::COL_W;
  localparam int RW = rbb_pkg::ROW_W;
  localparam int IW = rbb_pkg::RIDX_W;
  localparam int NW = rbb_pkg::CNT_W;
  localparam int DW = rbb_pkg::DIM_W;
  localparam int UW = rbb_pkg::RUN_W;

  // config
  logic [7:0]    origin_x_q, origin_y_q;
  logic [DW-1:0] width_q, height_q, w_dim, h_dim;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= DW'(rbb_pkg::MAX_WIDTH);
      height_q   <= DW'(rbb_pkg::MAX_HEIGHT);
    end else if (cfg_i.valid) begin
      unique case (rbb_pkg::cfg_idx_e'(cfg_i.index))
        rbb_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_i.data[7:0];
        rbb_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_i.data[7:0];
        rbb_pkg::CFG_WIDTH:    width_q    <= cfg_i.data;
        rbb_pkg::CFG_HEIGHT:   height_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_dim = (width_q == '0) ? DW'(1) :
            (width_q > DW'(rbb_pkg::MAX_WIDTH)) ? DW'(rbb_pkg::MAX_WIDTH) : width_q;
    h_dim = (height_q == '0) ? DW'(1) :
            (height_q > DW'(rbb_pkg::MAX_HEIGHT)) ? DW'(rbb_pkg::MAX_HEIGHT) : height_q;
  end

  state_e state_q;

  logic in_fire, out_fire, load_out;
  logic out_valid_q;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // pixel path
  logic [DW-1:0] pos_col_q, pos_row_q, col_next;
  logic          open_q;
  logic [CW-1:0] open_s_q, open_e_q;
  logic [NW-1:0] cur_cnt_q;
  logic [rbb_pkg::MAX_HEIGHT-1:0] cnt_vld_q;
  logic          px_fire, is_break, row_end, close_now, store;
  logic [CW-1:0] cl_s, cl_e, col;
  logic          clr_fire;

  assign col       = pos_col_q[CW-1:0];
  assign clr_fire  = in_fire && (rbb_pkg::op_e'(in_i.op) == rbb_pkg::OP_CLEAR);
  assign px_fire   = in_fire && (rbb_pkg::op_e'(in_i.op) == rbb_pkg::OP_PIXEL)
                     && (pos_row_q < h_dim);
  assign is_break  = (in_i.pixel == 8'd1);
  assign col_next  = pos_col_q + DW'(1);
  assign row_end   = (col_next >= w_dim);
  assign close_now = px_fire && ((is_break && open_q) || (!is_break && row_end));
  assign cl_s      = (is_break || open_q) ? open_s_q : col;
  assign cl_e      = is_break ? open_e_q : col;
  assign store     = close_now && (cur_cnt_q < NW'(rbb_pkg::MAX_RUNS_PER_ROW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_col_q <= '0;
      pos_row_q <= '0;
      open_q    <= 1'b0;
      cur_cnt_q <= '0;
      cnt_vld_q <= '0;
    end else if (clr_fire) begin
      pos_col_q <= '0;
      pos_row_q <= '0;
      open_q    <= 1'b0;
      cur_cnt_q <= '0;
      cnt_vld_q <= '0;
    end else if (px_fire) begin
      open_q <= !is_break && !row_end;
      if (store) begin
        cnt_vld_q[pos_row_q[RW-1:0]] <= 1'b1;
      end
      if (row_end) begin
        pos_col_q <= '0;
        pos_row_q <= pos_row_q + DW'(1);
        cur_cnt_q <= '0;
      end else begin
        pos_col_q <= col_next;
        if (store) begin
          cur_cnt_q <= cur_cnt_q + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_fire && !is_break) begin
      open_e_q <= col;
      if (!open_q) begin
        open_s_q <= col;
      end
    end
  end

  // fetch sequencer
  logic [RW-1:0] row_q;
  logic [IW-1:0] j_q, f_q;
  logic [NW-1:0] cnt_q, nf_q, nn_q;
  logic          bank_q;
  logic [CW-1:0] rs_q, re_q;
  rbb_pkg::box_ext_t ext_q;

  logic [UW-1:0] run_rdata, run_wdata;
  logic [2*CW-1:0] fr_rdata;
  logic [NW-1:0] cnt_rdata, cnt_val;
  logic          run_we, fr_we, take_first, take_grow, overlap, last_run;
  logic          r_taken;
  logic [CW-1:0] r_s, r_e;
  logic [RW+IW-1:0] run_waddr;
  logic [IW:0]   fr_waddr;

  assign cnt_val  = cnt_vld_q[row_q] ? cnt_rdata : '0;
  assign r_taken  = run_rdata[UW-1];
  assign r_s      = run_rdata[2*CW-1:CW];
  assign r_e      = run_rdata[CW-1:0];
  assign overlap  = (rs_q <= fr_rdata[CW-1:0]) && (fr_rdata[2*CW-1:CW] <= re_q);
  assign last_run = (NW'(j_q) + NW'(1) == cnt_q);

  assign take_first = (state_q == S_SCAN_CHK) && !r_taken;
  assign take_grow  = (state_q == S_FR) && overlap;

  always_comb begin
    run_we    = store || take_first || take_grow;
    run_waddr = store ? {pos_row_q[RW-1:0], cur_cnt_q[IW-1:0]} : {row_q, j_q};
    if (store) begin
      run_wdata = {1'b0, cl_s, cl_e};
    end else if (take_first) begin
      run_wdata = {1'b1, r_s, r_e};
    end else begin
      run_wdata = {1'b1, rs_q, re_q};
    end
    fr_we    = take_first || take_grow;
    fr_waddr = take_first ? {bank_q, IW'(0)} : {!bank_q, nn_q[IW-1:0]};
  end

  rbb_ram #(.WIDTH(UW), .DEPTH(rbb_pkg::RUN_DEPTH)) u_runs (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i ({row_q, j_q}),
    .rdata_o (run_rdata)
  );

  rbb_ram #(.WIDTH(NW), .DEPTH(rbb_pkg::MAX_HEIGHT)) u_counts (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (pos_row_q[RW-1:0]),
    .wdata_i (cur_cnt_q + NW'(1)),
    .raddr_i (row_q),
    .rdata_o (cnt_rdata)
  );

  rbb_ram #(.WIDTH(2*CW), .DEPTH(rbb_pkg::FR_DEPTH)) u_front (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (take_first ? {r_s, r_e} : {rs_q, re_q}),
    .raddr_i ({bank_q, f_q}),
    .rdata_o (fr_rdata)
  );

  // output
  logic              found_q, res_found_q;
  logic signed [8:0] bx, by, box_x_q, box_y_q;
  logic [8:0]        bw, bh, box_w_q, box_h_q;

  rbb_box u_box (
    .found_i      (found_q),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .ext_i        (ext_q),
    .box_x_o      (bx),
    .box_y_o      (by),
    .box_width_o  (bw),
    .box_height_o (bh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      j_q         <= '0;
      f_q         <= '0;
      cnt_q       <= '0;
      nf_q        <= '0;
      nn_q        <= '0;
      bank_q      <= 1'b0;
      found_q     <= 1'b0;
      rs_q        <= '0;
      re_q        <= '0;
      ext_q       <= '0;
      res_found_q <= 1'b0;
      box_x_q     <= '0;
      box_y_q     <= '0;
      box_w_q     <= '0;
      box_h_q     <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (rbb_pkg::op_e'(in_i.op) == rbb_pkg::OP_FETCH)) begin
            row_q   <= '0;
            found_q <= 1'b0;
            state_q <= S_ROW_RD;
          end
        end
        S_ROW_RD: state_q <= S_ROW_CNT;
        S_ROW_CNT: begin
          if (cnt_val != '0) begin
            j_q     <= IW'(cnt_val - NW'(1));
            state_q <= S_SCAN_RD;
          end else if (row_q == RW'(rbb_pkg::MAX_HEIGHT - 1)) begin
            state_q <= S_DONE;
          end else begin
            row_q   <= row_q + RW'(1);
            state_q <= S_ROW_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (!r_taken) begin
            found_q     <= 1'b1;
            ext_q.minx   <= r_s;
            ext_q.maxx   <= r_e;
            ext_q.top    <= row_q;
            ext_q.bottom <= row_q;
            nf_q        <= NW'(1);
            state_q     <= S_GROW;
          end else if (j_q != '0) begin
            j_q     <= j_q - IW'(1);
            state_q <= S_SCAN_RD;
          end else if (row_q == RW'(rbb_pkg::MAX_HEIGHT - 1)) begin
            state_q <= S_DONE;
          end else begin
            row_q   <= row_q + RW'(1);
            state_q <= S_ROW_RD;
          end
        end
        S_GROW: begin
          if (nf_q == '0 || row_q == RW'(rbb_pkg::MAX_HEIGHT - 1)) begin
            state_q <= S_DONE;
          end else begin
            row_q   <= row_q + RW'(1);
            nn_q    <= '0;
            state_q <= S_GCNT_RD;
          end
        end
        S_GCNT_RD: state_q <= S_GCNT;
        S_GCNT: begin
          cnt_q <= cnt_val;
          j_q   <= '0;
          if (cnt_val == '0) begin
            bank_q  <= !bank_q;
            nf_q    <= nn_q;
            state_q <= S_GROW;
          end else begin
            state_q <= S_GRUN_RD;
          end
        end
        S_GRUN_RD: state_q <= S_GRUN;
        S_GRUN: begin
          rs_q <= r_s;
          re_q <= r_e;
          f_q  <= '0;
          if (!r_taken) begin
            state_q <= S_FR_RD;
          end else if (last_run) begin
            bank_q  <= !bank_q;
            nf_q    <= nn_q;
            state_q <= S_GROW;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_GRUN_RD;
          end
        end
        S_FR_RD: state_q <= S_FR;
        S_FR: begin
          if (overlap || (NW'(f_q) + NW'(1) == nf_q)) begin
            if (overlap) begin
              nn_q         <= nn_q + NW'(1);
              ext_q.bottom <= row_q;
              if (rs_q < ext_q.minx) ext_q.minx <= rs_q;
              if (re_q > ext_q.maxx) ext_q.maxx <= re_q;
            end
            if (last_run) begin
              bank_q  <= !bank_q;
              nf_q    <= overlap ? nn_q + NW'(1) : nn_q;
              state_q <= S_GROW;
            end else begin
              j_q     <= j_q + IW'(1);
              state_q <= S_GRUN_RD;
            end
          end else begin
            f_q     <= f_q + IW'(1);
            state_q <= S_FR_RD;
          end
        end
        S_DONE: begin
          if (load_out) begin
            res_found_q <= found_q;
            box_x_q     <= bx;
            box_y_q     <= by;
            box_w_q     <= bw;
            box_h_q     <= bh;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = res_found_q;
  assign out_o.box_x      = box_x_q;
  assign out_o.box_y      = box_y_q;
  assign out_o.box_width  = box_w_q;
  assign out_o.box_height = box_h_q;

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NW'(rbb_pkg::MAX_RUNS_PER_ROW) && nn_q <= NW'(rbb_pkg::MAX_RUNS_PER_ROW))
    else $error("frontier count out of range");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_cnt_q <= NW'(rbb_pkg::MAX_RUNS_PER_ROW))
    else $error("row run count out of range");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.op == rbb_pkg::OP_FETCH) |=> !in_i.ready)
    else $error("fetch did not hold input");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_found_q |-> box_w_q == '0 && box_h_q == '0)
    else $error("empty result carries a box");

  a_no_take_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |-> !take_first && !take_grow)
    else $error("run memory write clash");

endmodule
